>>> src/nnfs_pkg.sv
// Shared constants for the nearest-neighbor frame scaler.
// Field widths, register indexes, size modes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nnfs_pkg;

  localparam int FRAME_AW   = 20;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 12;
  localparam int SRC_DIM_W  = 11;
  localparam int SCR_DIM_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W     = 2;
  localparam int KEEP_W     = 17;
  localparam int Q16_BITS   = 16;

  localparam logic [KEEP_W-1:0] KEEP_SUBTITLES = 17'd55706;
  localparam logic [KEEP_W-1:0] KEEP_FULL      = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_MODE         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTITLES_PRESENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTITLES_ENABLED = 3'd6;

  localparam logic [MODE_W-1:0] MODE_ORIGINAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIT      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FULL     = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [SRC_DIM_W-1:0] RST_SOURCE_WIDTH  = 11'd640;
  localparam logic [SRC_DIM_W-1:0] RST_SOURCE_HEIGHT = 11'd480;
  localparam logic [SCR_DIM_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [SCR_DIM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;

endpackage

`default_nettype wire

>>> src/nearest_neighbor_frame_scaler_unit.sv
// Top level of the nearest-neighbor frame scaler: item pipeline and frame store.
// Depends on nnfs_pkg and nnfs_geom (which holds nnfs_div).
`timescale 1ns / 1ps
`default_nettype none

// The block takes one item per clock whenever busy is low: a write stores one
// palette index into the 1M x 8 frame store, a read returns the scaled pixel.
// Each read gives exactly one result once its transfer has passed through the
// pipeline, shown for a single cycle with result_valid_o; the receiver cannot
// stall, so it must capture every strobe. Writes give no result. Busy is high
// after reset and after every configuration write while the geometry (frame
// size, steps and offsets) is recomputed on the shared bit-serial divider; aspect
// fit mode needs one more division than the other modes. DW, the width of that
// divider, is 41 bits at the default parameters.
// The frame store is not cleared; reading a pixel never written is undefined.

module nearest_neighbor_frame_scaler_unit #(
  parameter int MAX_SOURCE_WIDTH   = 1024,
  parameter int MAX_SOURCE_HEIGHT  = 1024,
  parameter int MAX_SCREEN_SIZE    = 4096,
  parameter int STEP_FRACTION_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            kind_i,
  input  wire logic [nnfs_pkg::FRAME_AW-1:0]   pixel_index_i,
  input  wire logic [nnfs_pkg::PIX_W-1:0]      pixel_value_i,
  input  wire logic [nnfs_pkg::COORD_W-1:0]    out_x_i,
  input  wire logic [nnfs_pkg::COORD_W-1:0]    out_y_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [nnfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nnfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                 result_valid_o,
  output logic [nnfs_pkg::PIX_W-1:0]           pixel_o,
  output logic [nnfs_pkg::COORD_W-1:0]         screen_x_o,
  output logic [nnfs_pkg::COORD_W-1:0]         screen_y_o,
  output logic                                 inside_res_o
);

  localparam int SWW   = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int SCW   = $clog2(MAX_SCREEN_SIZE + 1);
  localparam int FW    = (SWW > SHW ? (SWW > SCW ? SWW : SCW) : (SHW > SCW ? SHW : SCW));
  localparam int XSW   = SWW + STEP_FRACTION_BITS;
  localparam int YSW   = SHW + STEP_FRACTION_BITS;
  localparam int CW    = nnfs_pkg::COORD_W;
  localparam int AW    = nnfs_pkg::FRAME_AW;
  localparam int PXW   = CW + XSW;
  localparam int PYW   = CW + YSW;
  localparam int RXW   = CW + SWW;
  localparam int RYW   = CW + SHW;
  localparam int PRW   = SHW + SWW;
  localparam int NSTG  = 6;

  logic           accept;
  logic [SWW-1:0] sw;
  logic [SHW-1:0] sh;
  logic [FW-1:0]  fw, fh;
  logic [XSW-1:0] xstep;
  logic [YSW-1:0] ystep;
  logic [CW-1:0]  posx, posy;

  nnfs_geom #(
    .MAX_SOURCE_WIDTH   (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT  (MAX_SOURCE_HEIGHT),
    .MAX_SCREEN_SIZE    (MAX_SCREEN_SIZE),
    .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .sw_o       (sw),
    .sh_o       (sh),
    .fw_o       (fw),
    .fh_o       (fh),
    .xstep_o    (xstep),
    .ystep_o    (ystep),
    .posx_o     (posx),
    .posy_o     (posy)
  );

  assign accept = start && !busy;

  // Valid and kind bits for stages 1 to 6.
  logic [NSTG-1:0] v_q, rd_q;

  // Stage 1: captured coordinates, inside test and screen position.
  logic [CW-1:0]             ox1_q, oy1_q;
  logic                      in1_q;
  logic [CW-1:0]             scx1_q, scy1_q;
  logic [AW-1:0]             wa1_q, wa2_q, wa3_q, wa4_q;
  logic [nnfs_pkg::PIX_W-1:0] wd1_q, wd2_q, wd3_q, wd4_q, wd5_q;
  // Stage 2: step products.
  logic [PXW-1:0]            px2_q;
  logic [PYW-1:0]            py2_q;
  logic [RXW-1:0]            rx2;
  logic [RYW-1:0]            ry2;
  // Stage 3: clamped source column and row.
  logic [SWW-1:0]            sx3_q, sx4_q;
  logic [SHW-1:0]            sy3_q;
  // Stage 4: row base.
  logic [PRW-1:0]            base4_q;
  // Stage 5: frame address.
  logic [AW-1:0]             addr5_q;
  // Stage 6: read data.
  logic [nnfs_pkg::PIX_W-1:0] rdata_q;
  logic [CW-1:0]             scx_q [2:NSTG];
  logic [CW-1:0]             scy_q [2:NSTG];
  logic                      in_q  [2:NSTG];

  logic [nnfs_pkg::PIX_W-1:0] frame_mem [0:(1 << AW) - 1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      rd_q <= '0;
    end else begin
      v_q  <= {v_q[NSTG-2:0], accept};
      rd_q <= {rd_q[NSTG-2:0], kind_i == nnfs_pkg::KIND_READ};
    end
  end

  assign rx2 = px2_q[PXW-1:STEP_FRACTION_BITS];
  assign ry2 = py2_q[PYW-1:STEP_FRACTION_BITS];

  always_ff @(posedge clk_i) begin
    ox1_q  <= out_x_i;
    oy1_q  <= out_y_i;
    in1_q  <= (32'(out_x_i) < 32'(fw)) && (32'(out_y_i) < 32'(fh));
    scx1_q <= posx + out_x_i;
    scy1_q <= posy + out_y_i;
    wa1_q  <= pixel_index_i;
    wd1_q  <= pixel_value_i;

    px2_q <= PXW'(ox1_q * xstep);
    py2_q <= PYW'(oy1_q * ystep);
    wa2_q <= wa1_q;
    wd2_q <= wd1_q;

    sx3_q <= (rx2 >= RXW'(sw)) ? SWW'(sw - SWW'(1)) : rx2[SWW-1:0];
    sy3_q <= (ry2 >= RYW'(sh)) ? SHW'(sh - SHW'(1)) : ry2[SHW-1:0];
    wa3_q <= wa2_q;
    wd3_q <= wd2_q;

    base4_q <= PRW'(sy3_q * sw);
    sx4_q   <= sx3_q;
    wa4_q   <= wa3_q;
    wd4_q   <= wd3_q;

    // Writes take their index straight from the item; reads use row * width + column.
    addr5_q <= rd_q[3] ? AW'(base4_q + PRW'(sx4_q)) : wa4_q;
    wd5_q   <= wd4_q;

    // Reads and writes meet the store in the same stage, so item order is kept.
    if (v_q[4] && !rd_q[4]) frame_mem[addr5_q] <= wd5_q;
    rdata_q <= frame_mem[addr5_q];
  end

  // The placement and inside flag ride alongside the address path.
  always_ff @(posedge clk_i) begin
    scx_q[2] <= scx1_q;
    scy_q[2] <= scy1_q;
    in_q[2]  <= in1_q;
    for (int s = 3; s <= NSTG; s++) begin
      scx_q[s] <= scx_q[s-1];
      scy_q[s] <= scy_q[s-1];
      in_q[s]  <= in_q[s-1];
    end
  end

  assign result_valid_o = v_q[NSTG-1] && rd_q[NSTG-1];
  assign inside_res_o   = in_q[NSTG];
  assign screen_x_o     = scx_q[NSTG];
  assign screen_y_o     = scy_q[NSTG];
  assign pixel_o        = in_q[NSTG] ? rdata_q : '0;

  // A result appears only in answer to an accepted read.
  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && kind_i == nnfs_pkg::KIND_READ, NSTG))
    else $error("result without a matching read transfer");

  // Every accepted read produces its result.
  a_read_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == nnfs_pkg::KIND_READ) |-> ##NSTG result_valid_o)
    else $error("read transfer lost in the pipeline");

  // A configuration write holds off new items while geometry is rebuilt.
  a_cfg_sets_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("geometry recompute not started after configuration write");

  // No item enters the pipeline while busy.
  a_busy_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !v_q[0])
    else $error("item entered while busy");

endmodule

`default_nettype wire

>>> src/nnfs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the geometry sequencer; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nnfs_div #(
  parameter int DW = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int CW = $clog2(DW);

  logic          run_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, quo_q, dvs_q;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DW'(shifted - {1'b0, dvs_q}) : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/nnfs_geom.sv
// Configuration registers and geometry sequencer: frame size, steps, offsets.
// Depends on nnfs_pkg and nnfs_div.
`timescale 1ns / 1ps
`default_nettype none

module nnfs_geom #(
  parameter int MAX_SOURCE_WIDTH   = 1024,
  parameter int MAX_SOURCE_HEIGHT  = 1024,
  parameter int MAX_SCREEN_SIZE    = 4096,
  parameter int STEP_FRACTION_BITS = 16,
  localparam int SWW = $clog2(MAX_SOURCE_WIDTH + 1),
  localparam int SHW = $clog2(MAX_SOURCE_HEIGHT + 1),
  localparam int SCW = $clog2(MAX_SCREEN_SIZE + 1),
  localparam int FW  = (SWW > SHW ? (SWW > SCW ? SWW : SCW) : (SHW > SCW ? SHW : SCW)),
  localparam int XSW = SWW + STEP_FRACTION_BITS,
  localparam int YSW = SHW + STEP_FRACTION_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [nnfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nnfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                 busy_o,
  output logic [SWW-1:0]                       sw_o,
  output logic [SHW-1:0]                       sh_o,
  output logic [FW-1:0]                        fw_o,
  output logic [FW-1:0]                        fh_o,
  output logic [XSW-1:0]                       xstep_o,
  output logic [YSW-1:0]                       ystep_o,
  output logic [nnfs_pkg::COORD_W-1:0]         posx_o,
  output logic [nnfs_pkg::COORD_W-1:0]         posy_o
);

  localparam int AQW = SCW + nnfs_pkg::KEEP_W;
  localparam int RHW = AQW + SWW;
  localparam int LHW = SCW + SHW;
  localparam int D0  = RHW > LHW + nnfs_pkg::Q16_BITS ? RHW : LHW + nnfs_pkg::Q16_BITS;
  localparam int D1  = XSW > YSW ? XSW : YSW;
  localparam int DW  = D0 > D1 ? D0 : D1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLAMP  = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_MUL2   = 4'd3;
  localparam logic [3:0] ST_SIZE   = 4'd4;
  localparam logic [3:0] ST_SZWAIT = 4'd5;
  localparam logic [3:0] ST_FIX    = 4'd6;
  localparam logic [3:0] ST_STEPX  = 4'd7;
  localparam logic [3:0] ST_XWAIT  = 4'd8;
  localparam logic [3:0] ST_YWAIT  = 4'd9;

  logic [nnfs_pkg::SRC_DIM_W-1:0] src_w_q, src_h_q;
  logic [nnfs_pkg::SCR_DIM_W-1:0] scr_w_q, scr_h_q;
  logic [nnfs_pkg::MODE_W-1:0]    mode_q;
  logic                           sub_pres_q, sub_en_q;

  logic [3:0]     state_q;
  logic [SWW-1:0] sw_q, sw_c;
  logic [SHW-1:0] sh_q, sh_c;
  logic [SCW-1:0] wsc_q, hsc_q, wsc_c, hsc_c;
  logic [AQW-1:0] aq_q;
  logic [LHW-1:0] lhs_q;
  logic [RHW-1:0] rhs_q;
  logic           fit_q, fit_c;
  logic [FW-1:0]  fw_q, fh_q;
  logic [XSW-1:0] xstep_q;
  logic [YSW-1:0] ystep_q;
  logic [nnfs_pkg::COORD_W-1:0] posx_q, posy_q, posx_c, posy_c;
  logic [nnfs_pkg::KEEP_W-1:0]  keep_c;

  logic          div_start, div_done;
  logic [DW-1:0] div_dvd, div_dvs, div_q;

  always_comb begin
    int v;
    v = int'(src_w_q);
    if (v < 1) v = 1;
    if (v > MAX_SOURCE_WIDTH) v = MAX_SOURCE_WIDTH;
    sw_c = SWW'(v);
    v = int'(src_h_q);
    if (v < 1) v = 1;
    if (v > MAX_SOURCE_HEIGHT) v = MAX_SOURCE_HEIGHT;
    sh_c = SHW'(v);
    v = int'(scr_w_q);
    if (v < 1) v = 1;
    if (v > MAX_SCREEN_SIZE) v = MAX_SCREEN_SIZE;
    wsc_c = SCW'(v);
    v = int'(scr_h_q);
    if (v < 1) v = 1;
    if (v > MAX_SCREEN_SIZE) v = MAX_SCREEN_SIZE;
    hsc_c = SCW'(v);
  end

  assign keep_c = (sub_pres_q && sub_en_q) ? nnfs_pkg::KEEP_SUBTITLES : nnfs_pkg::KEEP_FULL;
  assign fit_c  = DW'({lhs_q, {nnfs_pkg::Q16_BITS{1'b0}}}) <= DW'(rhs_q);

  // Offsets: integer halving truncates toward zero, as the centering rule asks.
  always_comb begin
    int dx, dy;
    dx = (int'(wsc_q) - int'(fw_q)) / 2;
    dy = (int'(hsc_q) - int'(fh_q)) / 2;
    if (mode_q == nnfs_pkg::MODE_FULL) begin
      dx = 0;
      if (!sub_pres_q) dy = 0;
    end
    posx_c = nnfs_pkg::COORD_W'(dx);
    posy_c = nnfs_pkg::COORD_W'(dy);
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      ST_SIZE: begin
        div_start = mode_q == nnfs_pkg::MODE_FIT;
        div_dvd   = fit_c ? DW'(lhs_q) : DW'(rhs_q);
        div_dvs   = fit_c ? DW'(sw_q) : DW'({sh_q, {nnfs_pkg::Q16_BITS{1'b0}}});
      end
      ST_STEPX: begin
        div_start = 1'b1;
        div_dvd   = DW'({sw_q, {STEP_FRACTION_BITS{1'b0}}});
        div_dvs   = DW'(fw_q);
      end
      ST_XWAIT: begin
        div_start = div_done;
        div_dvd   = DW'({sh_q, {STEP_FRACTION_BITS{1'b0}}});
        div_dvs   = DW'(fh_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  nnfs_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= nnfs_pkg::RST_SOURCE_WIDTH;
      src_h_q    <= nnfs_pkg::RST_SOURCE_HEIGHT;
      scr_w_q    <= nnfs_pkg::RST_SCREEN_WIDTH;
      scr_h_q    <= nnfs_pkg::RST_SCREEN_HEIGHT;
      mode_q     <= nnfs_pkg::MODE_ORIGINAL;
      sub_pres_q <= 1'b0;
      sub_en_q   <= 1'b0;
      state_q    <= ST_CLAMP;
    end else if (cfg_we_i) begin
      state_q <= ST_CLAMP;
      case (cfg_idx_i)
        nnfs_pkg::REG_SOURCE_WIDTH:      src_w_q    <= cfg_data_i[nnfs_pkg::SRC_DIM_W-1:0];
        nnfs_pkg::REG_SOURCE_HEIGHT:     src_h_q    <= cfg_data_i[nnfs_pkg::SRC_DIM_W-1:0];
        nnfs_pkg::REG_SCREEN_WIDTH:      scr_w_q    <= cfg_data_i;
        nnfs_pkg::REG_SCREEN_HEIGHT:     scr_h_q    <= cfg_data_i;
        nnfs_pkg::REG_SIZE_MODE:         mode_q     <= cfg_data_i[nnfs_pkg::MODE_W-1:0];
        nnfs_pkg::REG_SUBTITLES_PRESENT: sub_pres_q <= cfg_data_i[0];
        nnfs_pkg::REG_SUBTITLES_ENABLED: sub_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end else begin
      case (state_q)
        ST_CLAMP:  state_q <= ST_MUL;
        ST_MUL:    state_q <= ST_MUL2;
        ST_MUL2:   state_q <= ST_SIZE;
        ST_SIZE:   state_q <= (mode_q == nnfs_pkg::MODE_FIT) ? ST_SZWAIT : ST_FIX;
        ST_SZWAIT: if (div_done) state_q <= ST_FIX;
        ST_FIX:    state_q <= ST_STEPX;
        ST_STEPX:  state_q <= ST_XWAIT;
        ST_XWAIT:  if (div_done) state_q <= ST_YWAIT;
        ST_YWAIT:  if (div_done) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_CLAMP: begin
        sw_q  <= sw_c;
        sh_q  <= sh_c;
        wsc_q <= wsc_c;
        hsc_q <= hsc_c;
      end
      ST_MUL: aq_q <= AQW'(hsc_q * keep_c);
      ST_MUL2: begin
        lhs_q <= LHW'(wsc_q * sh_q);
        rhs_q <= RHW'(aq_q * sw_q);
      end
      ST_SIZE: begin
        fit_q <= fit_c;
        case (mode_q)
          nnfs_pkg::MODE_FIT: begin
            fw_q <= FW'(wsc_q);
            fh_q <= FW'(aq_q[AQW-1:nnfs_pkg::Q16_BITS]);
          end
          nnfs_pkg::MODE_FULL: begin
            fw_q <= FW'(wsc_q);
            fh_q <= FW'(aq_q[AQW-1:nnfs_pkg::Q16_BITS]);
          end
          default: begin
            fw_q <= FW'(sw_q);
            fh_q <= FW'(sh_q);
          end
        endcase
      end
      ST_SZWAIT: begin
        if (div_done) begin
          if (fit_q) fh_q <= div_q[FW-1:0];
          else       fw_q <= div_q[FW-1:0];
        end
      end
      ST_FIX: begin
        if (fw_q == '0) fw_q <= FW'(1);
        if (fh_q == '0) fh_q <= FW'(1);
      end
      ST_STEPX: begin
        posx_q <= posx_c;
        posy_q <= posy_c;
      end
      ST_XWAIT: if (div_done) xstep_q <= div_q[XSW-1:0];
      ST_YWAIT: if (div_done) ystep_q <= div_q[YSW-1:0];
      default: begin
      end
    endcase
  end

  assign busy_o  = state_q != ST_IDLE;
  assign sw_o    = sw_q;
  assign sh_o    = sh_q;
  assign fw_o    = fw_q;
  assign fh_o    = fh_q;
  assign xstep_o = xstep_q;
  assign ystep_o = ystep_q;
  assign posx_o  = posx_q;
  assign posy_o  = posy_q;

endmodule

`default_nettype wire

>>> verif/nearest_neighbor_frame_scaler_unit_tb.sv
// Self-checking testbench for the nearest-neighbor frame scaler top level.
// Depends on nnfs_pkg and the scaler RTL; a scoreboard class predicts every read.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_frame_scaler_unit_tb;

  // One expected (or observed) answer to a read transfer.
  typedef struct {
    logic [nnfs_pkg::PIX_W-1:0]   pixel;
    logic [nnfs_pkg::COORD_W-1:0] screen_x;
    logic [nnfs_pkg::COORD_W-1:0] screen_y;
    logic                         in_frame;
  } scaled_pixel_t;

  // The scoreboard keeps its own copy of the registers and of every written
  // frame entry. Reads push an expected answer; writes only update the copy.
  class scaler_scoreboard;
    logic [nnfs_pkg::SRC_DIM_W-1:0] src_w, src_h;
    logic [nnfs_pkg::SCR_DIM_W-1:0] scr_w, scr_h;
    logic [nnfs_pkg::MODE_W-1:0]    mode;
    logic                           subs_present, subs_enabled;
    logic [nnfs_pkg::PIX_W-1:0]     frame[int];
    scaled_pixel_t                  expected_q[$];
    int                             errors;

    function void reset_state();
      src_w = nnfs_pkg::RST_SOURCE_WIDTH;
      src_h = nnfs_pkg::RST_SOURCE_HEIGHT;
      scr_w = nnfs_pkg::RST_SCREEN_WIDTH;
      scr_h = nnfs_pkg::RST_SCREEN_HEIGHT;
      mode = nnfs_pkg::MODE_ORIGINAL;
      subs_present = 1'b0;
      subs_enabled = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [nnfs_pkg::CFG_IDX_W-1:0] idx,
                            logic [nnfs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        nnfs_pkg::REG_SOURCE_WIDTH:      src_w = data[nnfs_pkg::SRC_DIM_W-1:0];
        nnfs_pkg::REG_SOURCE_HEIGHT:     src_h = data[nnfs_pkg::SRC_DIM_W-1:0];
        nnfs_pkg::REG_SCREEN_WIDTH:      scr_w = data;
        nnfs_pkg::REG_SCREEN_HEIGHT:     scr_h = data;
        nnfs_pkg::REG_SIZE_MODE:         mode = data[nnfs_pkg::MODE_W-1:0];
        nnfs_pkg::REG_SUBTITLES_PRESENT: subs_present = data[0];
        nnfs_pkg::REG_SUBTITLES_ENABLED: subs_enabled = data[0];
        default: ;
      endcase
    endfunction

    function longint unsigned clamp(longint unsigned v, longint unsigned lo,
                                    longint unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Works out the scaled frame for one read. src_addr is -1 when the
    // coordinate falls outside the scaled frame.
    function void map_read(input int ox, input int oy, output scaled_pixel_t res,
                           output int src_addr);
      longint unsigned sw, sh, scrw, scrh, keep, availq, fw, fh, xstep, ystep, sx, sy;
      longint posx, posy;
      sw = clamp(src_w, 1, 1024);
      sh = clamp(src_h, 1, 1024);
      scrw = clamp(scr_w, 1, 4096);
      scrh = clamp(scr_h, 1, 4096);
      keep = (subs_present && subs_enabled) ? nnfs_pkg::KEEP_SUBTITLES
                                            : nnfs_pkg::KEEP_FULL;
      availq = scrh * keep;
      fw = sw;
      fh = sh;
      if (mode == nnfs_pkg::MODE_FIT) begin
        if (scrw * sh * 65536 <= availq * sw) begin
          fw = scrw;
          fh = (sh * scrw) / sw;
        end else begin
          fw = (sw * availq) / (65536 * sh);
          fh = availq / 65536;
        end
      end else if (mode == nnfs_pkg::MODE_FULL) begin
        fw = scrw;
        fh = availq / 65536;
      end
      // A size that truncates to nothing is still one pixel.
      if (fw == 0) fw = 1;
      if (fh == 0) fh = 1;
      posx = (longint'(scrw) - longint'(fw)) / 2;
      posy = (longint'(scrh) - longint'(fh)) / 2;
      if (mode == nnfs_pkg::MODE_FULL) begin
        posx = 0;
        if (!subs_present) posy = 0;
      end
      res.screen_x = nnfs_pkg::COORD_W'(posx + ox);
      res.screen_y = nnfs_pkg::COORD_W'(posy + oy);
      res.in_frame = (ox < fw) && (oy < fh);
      src_addr = -1;
      if (res.in_frame) begin
        xstep = (sw << 16) / fw;
        ystep = (sh << 16) / fh;
        sx = (ox * xstep) >> 16;
        sy = (oy * ystep) >> 16;
        if (sx >= sw) sx = sw - 1;
        if (sy >= sh) sy = sh - 1;
        src_addr = int'((sy * sw + sx) & 64'hF_FFFF);
      end
    endfunction

    function bit is_written(int addr);
      return frame.exists(addr);
    endfunction

    // Notes one accepted input transfer.
    function void note_input(logic kind, logic [nnfs_pkg::FRAME_AW-1:0] idx,
                             logic [nnfs_pkg::PIX_W-1:0] val, int ox, int oy);
      scaled_pixel_t res;
      int addr;
      if (kind == nnfs_pkg::KIND_WRITE) begin
        frame[int'(idx)] = val;
      end else begin
        map_read(ox, oy, res, addr);
        res.pixel = (addr >= 0) ? frame[addr] : '0;
        expected_q.push_back(res);
      end
    endfunction

    // Checks one result transfer against the oldest expectation.
    function void check_result(scaled_pixel_t got);
      scaled_pixel_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d x=%0d y=%0d inside=%0d", $realtime,
                 got.pixel, got.screen_x, got.screen_y, got.in_frame);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.pixel !== exp_r.pixel) begin
        $display("%0t: pixel expected %0d actual %0d", $realtime, exp_r.pixel, got.pixel);
        errors++;
      end
      if (got.screen_x !== exp_r.screen_x) begin
        $display("%0t: screen_x expected %0d actual %0d", $realtime, exp_r.screen_x,
                 got.screen_x);
        errors++;
      end
      if (got.screen_y !== exp_r.screen_y) begin
        $display("%0t: screen_y expected %0d actual %0d", $realtime, exp_r.screen_y,
                 got.screen_y);
        errors++;
      end
      if (got.in_frame !== exp_r.in_frame) begin
        $display("%0t: inside_res expected %0d actual %0d", $realtime, exp_r.in_frame,
                 got.in_frame);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic                            kind_i = nnfs_pkg::KIND_WRITE;
  logic [nnfs_pkg::FRAME_AW-1:0]   pixel_index_i = '0;
  logic [nnfs_pkg::PIX_W-1:0]      pixel_value_i = '0;
  logic [nnfs_pkg::COORD_W-1:0]    out_x_i = '0;
  logic [nnfs_pkg::COORD_W-1:0]    out_y_i = '0;
  logic                            cfg_we_i = 1'b0;
  logic [nnfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [nnfs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            result_valid_o;
  logic [nnfs_pkg::PIX_W-1:0]      pixel_o;
  logic [nnfs_pkg::COORD_W-1:0]    screen_x_o;
  logic [nnfs_pkg::COORD_W-1:0]    screen_y_o;
  logic                            inside_res_o;

  scaler_scoreboard scoreboard = new();
  bit               idling_on;

  nearest_neighbor_frame_scaler_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .pixel_index_i  (pixel_index_i),
    .pixel_value_i  (pixel_value_i),
    .out_x_i        (out_x_i),
    .out_y_i        (out_y_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .pixel_o        (pixel_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .inside_res_o   (inside_res_o)
  );

  always #6 clk_i = ~clk_i;

  // Results cannot be held off, so every strobe is captured at the edge that
  // ends its cycle.
  always @(posedge clk_i) begin
    scaled_pixel_t got;
    if (rst_ni && result_valid_o) begin
      got.pixel = pixel_o;
      got.screen_x = screen_x_o;
      got.screen_y = screen_y_o;
      got.in_frame = inside_res_o;
      scoreboard.check_result(got);
    end
  end

  // Lowers start and lets the given number of cycles pass.
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Presents one item and holds it until the transfer happens. Start stays
  // high so that back-to-back items need no second assignment in one step.
  task automatic send_item(logic kind, logic [nnfs_pkg::FRAME_AW-1:0] idx,
                           logic [nnfs_pkg::PIX_W-1:0] val,
                           logic [nnfs_pkg::COORD_W-1:0] ox,
                           logic [nnfs_pkg::COORD_W-1:0] oy);
    start <= 1'b1;
    kind_i <= kind;
    pixel_index_i <= idx;
    pixel_value_i <= val;
    out_x_i <= ox;
    out_y_i <= oy;
    do @(posedge clk_i); while (busy);
    scoreboard.note_input(kind, idx, val, ox, oy);
    if (idling_on && $urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 12));
  endtask

  // A read of an entry never written has no defined answer, so the entry the
  // read lands on is written first when needed.
  task automatic send_read(logic [nnfs_pkg::COORD_W-1:0] ox,
                           logic [nnfs_pkg::COORD_W-1:0] oy);
    scaled_pixel_t res;
    int addr;
    scoreboard.map_read(ox, oy, res, addr);
    if (addr >= 0 && !scoreboard.is_written(addr))
      send_item(nnfs_pkg::KIND_WRITE, nnfs_pkg::FRAME_AW'(addr),
                nnfs_pkg::PIX_W'($urandom), '0, '0);
    send_item(nnfs_pkg::KIND_READ, nnfs_pkg::FRAME_AW'($urandom),
              nnfs_pkg::PIX_W'($urandom), ox, oy);
  endtask

  // Waits until every expected result has come, then lets a trailing write
  // leave the pipeline so that the block is truly idle.
  task automatic drain();
    idle_cycles(1);
    while (scoreboard.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Leaves the write enable high; configure lowers it after its last write.
  task automatic write_reg(logic [nnfs_pkg::CFG_IDX_W-1:0] idx,
                           logic [nnfs_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    scoreboard.write_reg(idx, data);
  endtask

  task automatic configure(int sw, int sh, int scrw, int scrh, int mode, int sp, int se);
    write_reg(nnfs_pkg::REG_SOURCE_WIDTH, nnfs_pkg::CFG_DATA_W'(sw));
    write_reg(nnfs_pkg::REG_SOURCE_HEIGHT, nnfs_pkg::CFG_DATA_W'(sh));
    write_reg(nnfs_pkg::REG_SCREEN_WIDTH, nnfs_pkg::CFG_DATA_W'(scrw));
    write_reg(nnfs_pkg::REG_SCREEN_HEIGHT, nnfs_pkg::CFG_DATA_W'(scrh));
    write_reg(nnfs_pkg::REG_SIZE_MODE, nnfs_pkg::CFG_DATA_W'(mode));
    write_reg(nnfs_pkg::REG_SUBTITLES_PRESENT, nnfs_pkg::CFG_DATA_W'(sp));
    write_reg(nnfs_pkg::REG_SUBTITLES_ENABLED, nnfs_pkg::CFG_DATA_W'(se));
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic for one register setting. Reads mostly aim near the
  // scaled frame so that both sides of its edges get hit.
  task automatic random_items(int count);
    int span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 1))
          send_item(nnfs_pkg::KIND_WRITE, nnfs_pkg::FRAME_AW'($urandom),
                    nnfs_pkg::PIX_W'($urandom), '0, '0);
        else
          send_item(nnfs_pkg::KIND_WRITE, nnfs_pkg::FRAME_AW'($urandom_range(0, 4095)),
                    nnfs_pkg::PIX_W'($urandom), '0, '0);
      end else if ($urandom_range(0, 3) == 0) begin
        send_read(nnfs_pkg::COORD_W'($urandom), nnfs_pkg::COORD_W'($urandom));
      end else begin
        span = (scoreboard.scr_w > 70) ? 70 : scoreboard.scr_w + 2;
        send_read(nnfs_pkg::COORD_W'($urandom_range(0, span)),
                  nnfs_pkg::COORD_W'($urandom_range(0, span)));
      end
    end
  endtask

  initial begin
    scoreboard.reset_state();
    idling_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset setting: value and index extremes, frame
    // corners, coordinates just outside and at the far end of the range.
    send_item(nnfs_pkg::KIND_WRITE, '1, 8'hFF, '0, '0);
    send_item(nnfs_pkg::KIND_WRITE, '0, 8'h00, '0, '0);
    send_read(12'd0, 12'd0);
    send_read(12'd639, 12'd479);
    send_read(12'd640, 12'd0);
    send_read(12'd0, 12'd480);
    send_read(12'd4095, 12'd4095);
    send_read(12'd320, 12'd240);
    drain();

    // Extreme settings: one-pixel source fit to a one-pixel screen, largest
    // sizes, out-of-range sizes, the unused mode, a source larger than the
    // screen, and a screen whose subtitle margin truncates height to zero.
    configure(1, 1, 1, 1, nnfs_pkg::MODE_FIT, 1, 1);
    send_read(12'd0, 12'd0);
    send_read(12'd1, 12'd0);
    random_items(40);
    drain();
    configure(1024, 1024, 4096, 4096, nnfs_pkg::MODE_FULL, 1, 0);
    send_read(12'd4095, 12'd4095);
    random_items(60);
    drain();
    configure(2047, 0, 8191, 0, nnfs_pkg::MODE_FIT, 0, 1);
    random_items(60);
    drain();
    configure(1024, 16, 64, 4096, 3, 1, 1);
    random_items(60);
    drain();
    configure(800, 600, 320, 200, nnfs_pkg::MODE_ORIGINAL, 0, 0);
    send_read(12'd799, 12'd599);
    random_items(60);
    drain();
    configure(7, 5, 4096, 1, nnfs_pkg::MODE_FULL, 1, 1);
    random_items(60);
    drain();

    // Random settings; every bit of the configuration data gets exercised.
    for (int p = 0; p < 10; p++) begin
      if (p == 9) idling_on = 1'b0;
      if ($urandom_range(0, 3) == 0)
        configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        configure($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 300),
                  $urandom_range(1, 300), $urandom_range(0, 3), $urandom_range(0, 1),
                  $urandom_range(0, 1));
      random_items(60);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (scoreboard.errors == 0 && scoreboard.expected_q.size() == 0) begin
      $display("PASS nearest_neighbor_frame_scaler_unit");
    end else begin
      if (scoreboard.expected_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $realtime,
                 scoreboard.expected_q.size());
      $display("FAIL nearest_neighbor_frame_scaler_unit");
    end
    $finish;
  end

  // Hard limit on the run in case the block stops answering.
  initial begin
    #30_000_000;
    $display("FAIL nearest_neighbor_frame_scaler_unit");
    $finish;
  end

endmodule

`default_nettype wire
